[src/sexlex_pkg.sv]
// ----------------------------------------------------------------------------
// sexlex_pkg
// Shared types and constants for the s-expression lexer: token tags,
// character codes and the result record.
// ----------------------------------------------------------------------------
package sexlex_pkg;

    // token tags
    localparam logic [2:0] TAG_OPEN   = 3'd0;
    localparam logic [2:0] TAG_CLOSE  = 3'd1;
    localparam logic [2:0] TAG_STRING = 3'd2;
    localparam logic [2:0] TAG_SYMBOL = 3'd3;
    localparam logic [2:0] TAG_END    = 3'd4;
    localparam logic [2:0] TAG_ERROR  = 3'd5;

    // character codes
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_OPEN     = 8'h28;
    localparam logic [7:0] CH_CLOSE    = 8'h29;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] SPACE_LIMIT = 8'd32;

    // one result record
    typedef struct packed {
        logic       has_char;
        logic [7:0] text_char;
        logic       token_done;
        logic [2:0] token_tag;
        logic       last;
    } t_result;

endpackage

[src/s_expression_lexer.sv]
// ----------------------------------------------------------------------------
// s_expression_lexer
// Byte-serial tokenizer for Lisp source text with streamed token text.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (i_s_tvalid / o_s_tready / i_s_tdata) takes one source
//   byte per request; a zero byte marks end of input.
//   Master channel (o_m_tvalid / i_m_tready / o_m_tdata / o_m_tuser /
//   o_m_tlast) gives the result records. o_m_tlast marks the final record
//   caused by one source byte; a byte may cause zero, one or two records.
//   A byte passes the input register, then decode, then the result
//   register, which gives its first record.
//   Throughput: one byte per cycle while each byte gives at most one
//   record and the receiver is ready. A byte that ends a symbol on a
//   paren gives two records and holds the result register until both
//   are taken. Bytes that give no record (whitespace, an opening quote,
//   a backslash in a string) pass even while the result register is busy.
//   Mode (begin, symbol, string, escape) is updated as each byte leaves
//   the input register, in order.
//   Reset (synchronous, active low) empties both registers and puts the
//   lexer in begin mode.
//   When the receiver stalls, the result register holds; the input
//   register still takes bytes until it holds one that gives a record,
//   then o_s_tready drops until the result register can take them.
// ----------------------------------------------------------------------------
module s_expression_lexer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] chr
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] text_char, [8] token_done, [15:9] zero
    output logic [3:0]  o_m_tuser,   // [0] has_char, [3:1] token_tag
    output logic        o_m_tlast    // last
);
    import sexlex_pkg::*;

    typedef enum logic [1:0] {
        MODE_BEGIN  = 2'd0,
        MODE_SYMBOL = 2'd1,
        MODE_STRING = 2'd2,
        MODE_ESCAPE = 2'd3
    } t_mode;

    // outcome of a byte handled in begin mode
    typedef struct packed {
        logic    hit;
        t_result res;
        t_mode   mode;
    } t_beg;

    function automatic t_result mk(input logic has, input logic [7:0] ch,
                                   input logic done, input logic [2:0] tag);
        t_result r;
        r.has_char   = has;
        r.text_char  = has ? ch : 8'h00;
        r.token_done = done;
        r.token_tag  = tag;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic t_beg beg(input logic [7:0] c);
        t_beg b;
        b.hit  = 1'b1;
        b.mode = MODE_BEGIN;
        b.res  = mk(1'b0, CH_NUL, 1'b1, TAG_END);
        if (c == CH_NUL) begin
            b.res = mk(1'b0, CH_NUL, 1'b1, TAG_END);
        end else if (c == CH_OPEN) begin
            b.res = mk(1'b1, c, 1'b1, TAG_OPEN);
        end else if (c == CH_CLOSE) begin
            b.res = mk(1'b1, c, 1'b1, TAG_CLOSE);
        end else if (c == CH_QUOTE) begin
            b.hit  = 1'b0;
            b.mode = MODE_STRING;
        end else if (c <= SPACE_LIMIT) begin
            b.hit = 1'b0;
        end else begin
            b.res  = mk(1'b1, c, 1'b0, TAG_SYMBOL);
            b.mode = MODE_SYMBOL;
        end
        return b;
    endfunction

    // registers
    logic       r_in_valid;
    logic [7:0] r_in_chr;
    t_mode      r_mode;
    t_result    r_res0;
    t_result    r_res1;
    logic [1:0] r_cnt;      // records still to deliver

    // decode
    t_mode      n_mode;
    t_result    d0, d1;
    logic [1:0] d_cnt;
    t_beg       b;

    always_comb begin
        n_mode = r_mode;
        d0     = mk(1'b0, CH_NUL, 1'b0, TAG_OPEN);
        d1     = mk(1'b0, CH_NUL, 1'b0, TAG_OPEN);
        d_cnt  = 2'd0;
        b      = beg(r_in_chr);
        unique case (r_mode)
            MODE_BEGIN: begin
                n_mode = b.mode;
                d0     = b.res;
                d_cnt  = {1'b0, b.hit};
            end
            MODE_SYMBOL: begin
                if (r_in_chr == CH_OPEN || r_in_chr == CH_CLOSE || r_in_chr == CH_QUOTE) begin
                    // symbol ends, the byte is taken again in begin mode
                    d0     = mk(1'b0, CH_NUL, 1'b1, TAG_SYMBOL);
                    d1     = b.res;
                    n_mode = b.mode;
                    d_cnt  = b.hit ? 2'd2 : 2'd1;
                end else if (r_in_chr <= SPACE_LIMIT) begin
                    d0     = mk(1'b0, CH_NUL, 1'b1, TAG_SYMBOL);
                    n_mode = MODE_BEGIN;
                    d_cnt  = 2'd1;
                end else begin
                    d0    = mk(1'b1, r_in_chr, 1'b0, TAG_SYMBOL);
                    d_cnt = 2'd1;
                end
            end
            MODE_STRING: begin
                if (r_in_chr == CH_NUL) begin
                    d0     = mk(1'b0, CH_NUL, 1'b1, TAG_ERROR);
                    n_mode = MODE_BEGIN;
                    d_cnt  = 2'd1;
                end else if (r_in_chr == CH_BSLASH) begin
                    n_mode = MODE_ESCAPE;
                end else if (r_in_chr == CH_QUOTE) begin
                    d0     = mk(1'b0, CH_NUL, 1'b1, TAG_STRING);
                    n_mode = MODE_BEGIN;
                    d_cnt  = 2'd1;
                end else begin
                    d0    = mk(1'b1, r_in_chr, 1'b0, TAG_STRING);
                    d_cnt = 2'd1;
                end
            end
            MODE_ESCAPE: begin
                if (r_in_chr < SPACE_LIMIT) begin
                    d0     = mk(1'b0, CH_NUL, 1'b1, TAG_ERROR);
                    n_mode = MODE_BEGIN;
                end else begin
                    d0     = mk(1'b1, r_in_chr, 1'b0, TAG_STRING);
                    n_mode = MODE_STRING;
                end
                d_cnt = 2'd1;
            end
            default: ;
        endcase
        // mark the final record of this byte
        if (d_cnt == 2'd2) begin
            d1.last = 1'b1;
        end else if (d_cnt == 2'd1) begin
            d0.last = 1'b1;
        end
    end

    // handshake
    logic pop, buf_free, advance, load;

    assign pop      = (r_cnt != 2'd0) && i_m_tready;
    assign buf_free = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop);
    assign advance  = r_in_valid && ((d_cnt == 2'd0) || buf_free);
    assign load     = advance && (d_cnt != 2'd0);

    assign o_s_tready = !r_in_valid || advance;
    assign o_m_tvalid = (r_cnt != 2'd0);
    assign o_m_tdata  = {7'd0, r_res0.token_done, r_res0.text_char};
    assign o_m_tuser  = {r_res0.token_tag, r_res0.has_char};
    assign o_m_tlast  = r_res0.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_BEGIN;
            r_cnt      <= 2'd0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_mode <= n_mode;
            end
            if (load) begin
                r_cnt <= d_cnt;
            end else if (pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
        // payload
        if (o_s_tready && i_s_tvalid) begin
            r_in_chr <= i_s_tdata;
        end
        if (load) begin
            r_res0 <= d0;
            r_res1 <= d1;
        end else if (pop) begin
            r_res0 <= r_res1;
        end
    end

    // assertions
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result count out of range");

    a_pair_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !r_res0.last)
        else $error("first of two records marked last");

    a_single_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1) |-> r_res0.last)
        else $error("final record not marked last");

    a_pair_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && i_m_tready) |=> (r_cnt == 2'd1 && o_m_tvalid))
        else $error("second record lost");

endmodule
